FILE: rtl/vigs_pkg.sv
`default_nettype none

package vigs_pkg;

  localparam int MAX_DIM    = 64;
  localparam int COORD_W    = 6;
  localparam int VOX_W      = 8;
  localparam int GRAD_W     = 16;
  localparam int RES_W      = 7;
  localparam int STEP_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam int DEPTH   = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PLANE_W = 2 * RES_W;
  localparam int TOTAL_W = 3 * RES_W;
  localparam int OFS_W   = COORD_W + 2;
  localparam int SUM_W   = OFS_W + PLANE_W + 2;
  localparam int SLOT_W  = 3;

  // gradient: |d| * 128 / s done as |d| * ceil(2^19 / s) >> 12, exact for |d| < 256
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int QUO_SHIFT   = RECIP_SHIFT - 7;
  localparam int PROD_W      = VOX_W + RECIP_W;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RES_X     = 3'd0,
    CFG_RES_Y     = 3'd1,
    CFG_RES_Z     = 3'd2,
    CFG_ISO_LEVEL = 3'd3,
    CFG_STEP_X    = 3'd4,
    CFG_STEP_Y    = 3'd5,
    CFG_STEP_Z    = 3'd6
  } cfg_idx_e;

  // read order of one sample
  typedef enum logic [SLOT_W-1:0] {
    SLOT_CENTER = 3'd0,
    SLOT_X_LO   = 3'd1,
    SLOT_X_HI   = 3'd2,
    SLOT_Y_LO   = 3'd3,
    SLOT_Y_HI   = 3'd4,
    SLOT_Z_LO   = 3'd5,
    SLOT_Z_HI   = 3'd6
  } slot_e;

  typedef struct packed {
    logic               command;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [VOX_W-1:0]   voxel_value;
  } vigs_in_t;

  typedef struct packed {
    logic                     hit;
    logic [COORD_W-1:0]       out_x;
    logic [COORD_W-1:0]       out_y;
    logic [COORD_W-1:0]       out_z;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
  } vigs_out_t;

  typedef struct packed {
    logic                    valid;
    logic                    write;
    slot_e                   slot;
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic [COORD_W-1:0]      z;
    logic [VOX_W-1:0]        wdata;
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
    logic signed [OFS_W-1:0] oz;
  } vigs_op1_t;

  typedef struct packed {
    logic                    valid;
    logic                    write;
    slot_e                   slot;
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic [COORD_W-1:0]      z;
    logic [VOX_W-1:0]        wdata;
    logic signed [SUM_W-1:0] tx;
    logic signed [SUM_W-1:0] ty;
    logic signed [SUM_W-1:0] tz;
  } vigs_op2_t;

  typedef struct packed {
    logic               valid;
    slot_e              slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [VOX_W-1:0]   data;
  } vigs_rd_t;

  function automatic logic [RES_W-1:0] eff_res(input logic [RES_W-1:0] r);
    logic [RES_W-1:0] e;
    e = r;
    if (r == '0) begin
      e = RES_W'(1);
    end else if (int'(r) > MAX_DIM) begin
      e = RES_W'(MAX_DIM);
    end
    return e;
  endfunction

  function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] s);
    return (s == '0) ? STEP_W'(1) : s;
  endfunction

  function automatic logic [RECIP_W-1:0] step_recip(input logic [STEP_W-1:0] s);
    logic [RECIP_W-1:0] r;
    unique case (s) inside
      4'd0, 4'd1: r = RECIP_W'(524288);
      4'd2:       r = RECIP_W'(262144);
      4'd3:       r = RECIP_W'(174763);
      4'd4:       r = RECIP_W'(131072);
      4'd5:       r = RECIP_W'(104858);
      4'd6:       r = RECIP_W'(87382);
      4'd7:       r = RECIP_W'(74899);
      4'd8:       r = RECIP_W'(65536);
      4'd9:       r = RECIP_W'(58255);
      4'd10:      r = RECIP_W'(52429);
      4'd11:      r = RECIP_W'(47663);
      4'd12:      r = RECIP_W'(43691);
      4'd13:      r = RECIP_W'(40330);
      4'd14:      r = RECIP_W'(37450);
      4'd15:      r = RECIP_W'(34953);
      default:    r = RECIP_W'(524288);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vigs_seq.sv
`default_nettype none

module vigs_seq import vigs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire vigs_in_t           in_data_i,
  input  wire logic               advance_i,
  input  wire logic [STEP_W-1:0]  step_x_i,
  input  wire logic [STEP_W-1:0]  step_y_i,
  input  wire logic [STEP_W-1:0]  step_z_i,
  input  wire logic [RES_W-1:0]   res_x_i,
  input  wire logic [PLANE_W-1:0] plane_i,
  output vigs_op2_t               op2_o
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SAMPLE = 2'b10
  } state_e;

  state_e    state_q, state_d;
  slot_e     slot_q, slot_d;
  vigs_in_t  item_q, item_d;
  vigs_op1_t op1_q, op1_d;
  vigs_op2_t op2_q, op2_d;
  vigs_in_t  src;
  slot_e     emit_slot;
  logic      emit_valid;
  logic      emit_write;
  logic      accept;

  assign in_ready_o = advance_i && (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // at most one memory transaction per cycle while advance_i is high: a write, or one of the seven sample reads
  always_comb begin
    emit_valid = 1'b0;
    emit_write = 1'b0;
    emit_slot  = slot_q;
    src        = item_q;
    unique case (state_q)
      ST_IDLE: begin
        src        = in_data_i;
        emit_valid = accept;
        emit_write = (in_data_i.command == CMD_WRITE);
        emit_slot  = SLOT_CENTER;
      end
      ST_SAMPLE: begin
        emit_valid = 1'b1;
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    op1_d       = '0;
    op1_d.valid = emit_valid;
    op1_d.write = emit_write;
    op1_d.slot  = emit_slot;
    op1_d.x     = src.coord_x;
    op1_d.y     = src.coord_y;
    op1_d.z     = src.coord_z;
    op1_d.wdata = src.voxel_value;
    op1_d.ox    = $signed(OFS_W'(src.coord_x));
    op1_d.oy    = $signed(OFS_W'(src.coord_y));
    op1_d.oz    = $signed(OFS_W'(src.coord_z));
    case (emit_slot)
      SLOT_X_LO: op1_d.ox = op1_d.ox - $signed(OFS_W'(step_x_i));
      SLOT_X_HI: op1_d.ox = op1_d.ox + $signed(OFS_W'(step_x_i));
      SLOT_Y_LO: op1_d.oy = op1_d.oy - $signed(OFS_W'(step_y_i));
      SLOT_Y_HI: op1_d.oy = op1_d.oy + $signed(OFS_W'(step_y_i));
      SLOT_Z_LO: op1_d.oz = op1_d.oz - $signed(OFS_W'(step_z_i));
      SLOT_Z_HI: op1_d.oz = op1_d.oz + $signed(OFS_W'(step_z_i));
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    item_d  = item_q;
    if (advance_i) begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && in_data_i.command == CMD_SAMPLE) begin
            state_d = ST_SAMPLE;
            slot_d  = SLOT_X_LO;
            item_d  = in_data_i;
          end
        end
        ST_SAMPLE: begin
          if (slot_q == SLOT_Z_HI) begin
            state_d = ST_IDLE;
          end else begin
            slot_d = slot_e'(slot_q + SLOT_W'(1));
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  // linear index terms
  always_comb begin
    op2_d       = '0;
    op2_d.valid = op1_q.valid;
    op2_d.write = op1_q.write;
    op2_d.slot  = op1_q.slot;
    op2_d.x     = op1_q.x;
    op2_d.y     = op1_q.y;
    op2_d.z     = op1_q.z;
    op2_d.wdata = op1_q.wdata;
    op2_d.tx    = SUM_W'(op1_q.ox);
    op2_d.ty    = SUM_W'(op1_q.oy) * $signed(SUM_W'(res_x_i));
    op2_d.tz    = SUM_W'(op1_q.oz) * $signed(SUM_W'(plane_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= SLOT_CENTER;
      op1_q   <= '0;
      op2_q   <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      if (advance_i) begin
        op1_q <= op1_d;
        op2_q <= op2_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign op2_o = op2_q;

endmodule

`default_nettype wire

FILE: rtl/vigs_store.sv
`default_nettype none

module vigs_store import vigs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire vigs_op2_t          op2_i,
  input  wire logic [TOTAL_W-1:0] total_i,
  output vigs_rd_t                rd_o
);

  logic [VOX_W-1:0]        mem_q [DEPTH];
  logic [VOX_W-1:0]        rdata_q;
  logic                    rd_valid_q;
  slot_e                   rd_slot_q;
  logic [COORD_W-1:0]      rd_x_q, rd_y_q, rd_z_q;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] tot_s;
  logic signed [SUM_W-1:0] idx;
  logic [ADDR_W-1:0]       addr;

  // clamp to the configured volume
  always_comb begin
    sum   = op2_i.tx + op2_i.ty + op2_i.tz;
    tot_s = $signed(SUM_W'(total_i));
    if (sum[SUM_W-1]) begin
      idx = '0;
    end else if (sum >= tot_s) begin
      idx = tot_s - $signed(SUM_W'(1));
    end else begin
      idx = sum;
    end
  end

  assign addr = idx[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (advance_i && op2_i.valid) begin
      if (op2_i.write) begin
        mem_q[addr] <= op2_i.wdata;
      end else begin
        rdata_q <= mem_q[addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (advance_i) begin
      rd_valid_q <= op2_i.valid && !op2_i.write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      rd_slot_q <= op2_i.slot;
      rd_x_q    <= op2_i.x;
      rd_y_q    <= op2_i.y;
      rd_z_q    <= op2_i.z;
    end
  end

  assign rd_o.valid = rd_valid_q;
  assign rd_o.slot  = rd_slot_q;
  assign rd_o.x     = rd_x_q;
  assign rd_o.y     = rd_y_q;
  assign rd_o.z     = rd_z_q;
  assign rd_o.data  = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/vigs_grad.sv
`default_nettype none

module vigs_grad import vigs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire vigs_rd_t          rd_i,
  input  wire logic [VOX_W-1:0]  iso_level_i,
  input  wire logic [STEP_W-1:0] step_x_i,
  input  wire logic [STEP_W-1:0] step_y_i,
  input  wire logic [STEP_W-1:0] step_z_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output vigs_out_t              out_data_o
);

  logic                     hit_q;
  logic [COORD_W-1:0]       x_q, y_q, z_q;
  logic [VOX_W-1:0]         before_q;
  logic signed [GRAD_W-1:0] grad_x_q, grad_y_q;
  vigs_out_t                out_q;
  logic                     out_valid_q, out_valid_d;
  logic                     take;
  logic                     last;
  logic signed [VOX_W:0]    diff;
  logic [VOX_W:0]           mag9;
  logic [STEP_W-1:0]        step_sel;
  logic [PROD_W-1:0]        prod;
  logic [GRAD_W-1:0]        quo;
  logic signed [GRAD_W-1:0] grad_val;

  // last read of a sample may not land on an occupied result register
  assign last      = rd_i.valid && (rd_i.slot == SLOT_Z_HI);
  assign advance_o = !(last && out_valid_q && !out_ready_i);
  assign take      = rd_i.valid && advance_o;

  always_comb begin
    diff = $signed({1'b0, before_q}) - $signed({1'b0, rd_i.data});
    mag9 = diff[VOX_W] ? unsigned'(-diff) : unsigned'(diff);
    case (rd_i.slot)
      SLOT_X_HI: step_sel = step_x_i;
      SLOT_Y_HI: step_sel = step_y_i;
      default:   step_sel = step_z_i;
    endcase
    prod     = PROD_W'(mag9[VOX_W-1:0]) * PROD_W'(step_recip(step_sel));
    quo      = GRAD_W'(prod >> QUO_SHIFT);
    grad_val = diff[VOX_W] ? -$signed(quo) : $signed(quo);
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      case (rd_i.slot) inside
        SLOT_CENTER: begin
          hit_q <= (rd_i.data > iso_level_i);
          x_q   <= rd_i.x;
          y_q   <= rd_i.y;
          z_q   <= rd_i.z;
        end
        SLOT_X_LO, SLOT_Y_LO, SLOT_Z_LO: begin
          before_q <= rd_i.data;
        end
        SLOT_X_HI: grad_x_q <= grad_val;
        SLOT_Y_HI: grad_y_q <= grad_val;
        SLOT_Z_HI: begin
          out_q.hit    <= hit_q;
          out_q.out_x  <= x_q;
          out_q.out_y  <= y_q;
          out_q.out_z  <= z_q;
          out_q.grad_x <= hit_q ? grad_x_q : '0;
          out_q.grad_y <= hit_q ? grad_y_q : '0;
          out_q.grad_z <= hit_q ? grad_val : '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take && last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/voxel_iso_gradient_sampler.sv
// reads pass the op1, op2 and ram read registers; the last read sets the result register
// the seven reads of a sample share the single-port voxel ram, and block new input
// write transactions use one ram access each and give no result
// reset sets the config and control registers and empties the pipeline, no clearing pass
// voxel ram contents are not reset and stay undefined until written
`default_nettype none

module voxel_iso_gradient_sampler import vigs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire vigs_in_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output vigs_out_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [RES_W-1:0]   res_x_q, res_y_q, res_z_q;
  logic [VOX_W-1:0]   iso_level_q;
  logic [STEP_W-1:0]  step_x_q, step_y_q, step_z_q;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [RES_W-1:0]   rx_eff;
  logic [STEP_W-1:0]  sx_eff, sy_eff, sz_eff;
  logic               advance;
  vigs_op2_t          op2;
  vigs_rd_t           rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_x_q     <= RES_W'(64);
      res_y_q     <= RES_W'(64);
      res_z_q     <= RES_W'(64);
      iso_level_q <= '0;
      step_x_q    <= STEP_W'(1);
      step_y_q    <= STEP_W'(1);
      step_z_q    <= STEP_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RES_X:     res_x_q     <= cfg_wdata_i[RES_W-1:0];
        CFG_RES_Y:     res_y_q     <= cfg_wdata_i[RES_W-1:0];
        CFG_RES_Z:     res_z_q     <= cfg_wdata_i[RES_W-1:0];
        CFG_ISO_LEVEL: iso_level_q <= cfg_wdata_i[VOX_W-1:0];
        CFG_STEP_X:    step_x_q    <= cfg_wdata_i[STEP_W-1:0];
        CFG_STEP_Y:    step_y_q    <= cfg_wdata_i[STEP_W-1:0];
        CFG_STEP_Z:    step_z_q    <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign rx_eff  = eff_res(res_x_q);
  assign sx_eff  = eff_step(step_x_q);
  assign sy_eff  = eff_step(step_y_q);
  assign sz_eff  = eff_step(step_z_q);
  assign plane_d = PLANE_W'(rx_eff) * PLANE_W'(eff_res(res_y_q));
  assign total_d = TOTAL_W'(plane_q) * TOTAL_W'(eff_res(res_z_q));

  always_ff @(posedge clk_i) begin
    plane_q <= plane_d;
    total_q <= total_d;
  end

  vigs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .step_x_i   (sx_eff),
    .step_y_i   (sy_eff),
    .step_z_i   (sz_eff),
    .res_x_i    (rx_eff),
    .plane_i    (plane_q),
    .op2_o      (op2)
  );

  vigs_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .op2_i     (op2),
    .total_i   (total_q),
    .rd_o      (rd)
  );

  vigs_grad u_grad (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_i        (rd),
    .iso_level_i (iso_level_q),
    .step_x_i    (sx_eff),
    .step_y_i    (sy_eff),
    .step_z_i    (sz_eff),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: sim/voxel_iso_gradient_sampler_test.sv
`default_nettype none

module voxel_iso_gradient_sampler_test;
  import vigs_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 195;
  localparam int TIMEOUT_UNITS = 5_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam int RX_OPEN   = 0;
  localparam int RX_JITTER = 1;
  localparam int RX_BURSTY = 2;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WRITE,
    ROW_SAMPLE
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [7:0]           reg_val;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [COORD_W-1:0]   z;
    logic [VOX_W-1:0]     val;
    logic                 typed;
    vigs_out_t            want;
  } row_t;

  localparam vigs_out_t NO_RES = '0;
  localparam int PLAN_ROWS = 30;

  localparam row_t PLAN [PLAN_ROWS] = '{
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd0, 6'd0, 6'd0, 8'd255, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd1, 6'd0, 6'd0, 8'd0, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd0, 6'd1, 6'd0, 8'd0, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd0, 6'd0, 6'd1, 8'd0, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_SPARE, 8'd0, 6'd0, 6'd0, 6'd0, 8'd0, 1'b1,
      '{1'b1, 6'd0, 6'd0, 6'd0, 16'sd32640, 16'sd32640, 16'sd32640}},
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd1, 6'd1, 6'd1, 8'd128, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd0, 6'd1, 6'd1, 8'd0, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd2, 6'd1, 6'd1, 8'd255, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd1, 6'd0, 6'd1, 8'd255, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd1, 6'd2, 6'd1, 8'd0, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd1, 6'd1, 6'd0, 8'd7, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd1, 6'd1, 6'd2, 8'd7, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_SPARE, 8'd0, 6'd1, 6'd1, 6'd1, 8'd0, 1'b1,
      '{1'b1, 6'd1, 6'd1, 6'd1, -16'sd32640, 16'sd32640, 16'sd0}},
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd63, 6'd63, 6'd63, 8'd0, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_SPARE, 8'd0, 6'd63, 6'd63, 6'd63, 8'd255, 1'b1,
      '{1'b0, 6'd63, 6'd63, 6'd63, 16'sd0, 16'sd0, 16'sd0}},
    '{ROW_CFG,    CFG_ISO_LEVEL, 8'd255, 6'd0, 6'd0, 6'd0, 8'd0, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_SPARE, 8'd0, 6'd0, 6'd0, 6'd0, 8'd0, 1'b1,
      '{1'b0, 6'd0, 6'd0, 6'd0, 16'sd0, 16'sd0, 16'sd0}},
    '{ROW_CFG,    CFG_ISO_LEVEL, 8'd127, 6'd0, 6'd0, 6'd0, 8'd0, 1'b0, NO_RES},
    '{ROW_CFG,    CFG_STEP_X, 8'd0, 6'd0, 6'd0, 6'd0, 8'd0, 1'b0, NO_RES},
    '{ROW_CFG,    CFG_STEP_Y, 8'd15, 6'd0, 6'd0, 6'd0, 8'd0, 1'b0, NO_RES},
    '{ROW_CFG,    CFG_STEP_Z, 8'd8, 6'd0, 6'd0, 6'd0, 8'd0, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_SPARE, 8'd0, 6'd1, 6'd1, 6'd1, 8'd90, 1'b0, NO_RES},
    '{ROW_CFG,    CFG_RES_X, 8'd0, 6'd0, 6'd0, 6'd0, 8'd0, 1'b0, NO_RES},
    '{ROW_CFG,    CFG_RES_Y, 8'd127, 6'd0, 6'd0, 6'd0, 8'd0, 1'b0, NO_RES},
    '{ROW_CFG,    CFG_RES_Z, 8'd1, 6'd0, 6'd0, 6'd0, 8'd0, 1'b0, NO_RES},
    '{ROW_WRITE,  REG_SPARE, 8'd0, 6'd40, 6'd50, 6'd60, 8'd200, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_SPARE, 8'd0, 6'd5, 6'd9, 6'd0, 8'd0, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_SPARE, 8'd0, 6'd63, 6'd63, 6'd63, 8'd0, 1'b0, NO_RES},
    '{ROW_CFG,    REG_SPARE, 8'd255, 6'd0, 6'd0, 6'd0, 8'd0, 1'b0, NO_RES},
    '{ROW_SAMPLE, REG_SPARE, 8'd0, 6'd63, 6'd63, 6'd63, 8'd0, 1'b0, NO_RES}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  vigs_in_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  vigs_out_t            out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_RES_X;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // shadow of the block's registers and voxel memory
  logic [RES_W-1:0]  dim_x = RES_W'(MAX_DIM);
  logic [RES_W-1:0]  dim_y = RES_W'(MAX_DIM);
  logic [RES_W-1:0]  dim_z = RES_W'(MAX_DIM);
  logic [VOX_W-1:0]  iso_thr = '0;
  logic [STEP_W-1:0] dist_x = STEP_W'(1);
  logic [STEP_W-1:0] dist_y = STEP_W'(1);
  logic [STEP_W-1:0] dist_z = STEP_W'(1);
  logic [VOX_W-1:0]  vox_mem [DEPTH];
  bit                vox_seen [DEPTH];

  vigs_out_t sample_results_due [$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  int        win_lo [3];
  int        win_span [3];
  int        rx_tick = 0;
  int        rx_mode = RX_OPEN;
  int        rx_hold = 0;

  voxel_iso_gradient_sampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic int eff_dim(input logic [RES_W-1:0] r);
    if (r == '0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  function automatic int eff_dist(input logic [STEP_W-1:0] s);
    return (s == '0) ? 1 : int'(s);
  endfunction

  function automatic int voxel_lin(input int x, input int y, input int z);
    int rx, ry, total, idx;
    rx = eff_dim(dim_x);
    ry = eff_dim(dim_y);
    total = rx * ry * eff_dim(dim_z);
    idx = x + y * rx + z * rx * ry;
    if (idx < 0) idx = 0;
    if (idx >= total) idx = total - 1;
    return idx;
  endfunction

  function automatic logic signed [GRAD_W-1:0] grad_q8(input int lo, input int hi,
                                                      input int d);
    int q;
    q = ((lo - hi) * 256) / (2 * d);
    return q[GRAD_W-1:0];
  endfunction

  function automatic vigs_out_t predict_sample(input int x, input int y, input int z);
    vigs_out_t r;
    int dx, dy, dz;
    dx = eff_dist(dist_x);
    dy = eff_dist(dist_y);
    dz = eff_dist(dist_z);
    r = '0;
    r.hit = int'(vox_mem[voxel_lin(x, y, z)]) > int'(iso_thr);
    r.out_x = COORD_W'(x);
    r.out_y = COORD_W'(y);
    r.out_z = COORD_W'(z);
    if (r.hit) begin
      r.grad_x = grad_q8(vox_mem[voxel_lin(x - dx, y, z)], vox_mem[voxel_lin(x + dx, y, z)], dx);
      r.grad_y = grad_q8(vox_mem[voxel_lin(x, y - dy, z)], vox_mem[voxel_lin(x, y + dy, z)], dy);
      r.grad_z = grad_q8(vox_mem[voxel_lin(x, y, z - dz)], vox_mem[voxel_lin(x, y, z + dz)], dz);
    end
    return r;
  endfunction

  function automatic int pick_voxel();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int pick_coord(input int axis);
    if ($urandom_range(0, 6) == 0) return $urandom_range(0, 63);
    return win_lo[axis] + $urandom_range(0, win_span[axis] - 1);
  endfunction

  function automatic int pick_res();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
  endfunction

  task automatic push_item(input cmd_e cmd, input int x, input int y, input int z,
                           input int v, input bit typed = 1'b0,
                           input vigs_out_t want = '0);
    vigs_in_t it;
    vigs_out_t due;
    int a;
    it.command = cmd;
    it.coord_x = COORD_W'(x);
    it.coord_y = COORD_W'(y);
    it.coord_z = COORD_W'(z);
    it.voxel_value = VOX_W'(v);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 14) : $urandom_range(1, 3))
        @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (cmd == CMD_WRITE) begin
      a = voxel_lin(x, y, z);
      vox_mem[a] = VOX_W'(v);
      vox_seen[a] = 1'b1;
    end else begin
      due = typed ? want : predict_sample(x, y, z);
      sample_results_due = {sample_results_due, due};
    end
    burst_left--;
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // all seven reads of a sample must land on written voxels
  task automatic sample_at(input int x, input int y, input int z, input int v,
                           input bit typed = 1'b0, input vigs_out_t want = '0);
    int dx, dy, dz, rx, ry, a;
    int near [7];
    dx = eff_dist(dist_x);
    dy = eff_dist(dist_y);
    dz = eff_dist(dist_z);
    rx = eff_dim(dim_x);
    ry = eff_dim(dim_y);
    near = '{voxel_lin(x, y, z),
             voxel_lin(x - dx, y, z), voxel_lin(x + dx, y, z),
             voxel_lin(x, y - dy, z), voxel_lin(x, y + dy, z),
             voxel_lin(x, y, z - dz), voxel_lin(x, y, z + dz)};
    for (int i = 0; i < 7; i++) begin
      a = near[i];
      if (!vox_seen[a])
        push_item(CMD_WRITE, a % rx, (a / rx) % ry, a / (rx * ry), pick_voxel());
    end
    push_item(CMD_SAMPLE, x, y, z, v, typed, want);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sample_results_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    drain();
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    case (idx)
      CFG_RES_X:     dim_x = val[RES_W-1:0];
      CFG_RES_Y:     dim_y = val[RES_W-1:0];
      CFG_RES_Z:     dim_z = val[RES_W-1:0];
      CFG_ISO_LEVEL: iso_thr = val;
      CFG_STEP_X:    dist_x = val[STEP_W-1:0];
      CFG_STEP_Y:    dist_y = val[STEP_W-1:0];
      CFG_STEP_Z:    dist_z = val[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    rx_tick++;
    if (rx_tick % 256 == 0) rx_mode = $urandom_range(RX_OPEN, RX_BURSTY);
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i = 1'b0;
    end else if (rx_mode == RX_BURSTY && $urandom_range(0, 15) == 0) begin
      rx_hold = $urandom_range(2, 19);
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = (rx_mode != RX_JITTER) || ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk_i) begin
    vigs_out_t due;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (sample_results_due.size() == 0) begin
        $error("result transaction with no sample outstanding");
        mismatches++;
      end else begin
        due = sample_results_due.pop_front();
        check_field("hit", due.hit, out_data_o.hit);
        check_field("out_x", due.out_x, out_data_o.out_x);
        check_field("out_y", due.out_y, out_data_o.out_y);
        check_field("out_z", due.out_z, out_data_o.out_z);
        check_field("grad_x", $signed(due.grad_x), $signed(out_data_o.grad_x));
        check_field("grad_y", $signed(due.grad_y), $signed(out_data_o.grad_y));
        check_field("grad_z", $signed(due.grad_z), $signed(out_data_o.grad_z));
      end
    end
  end

  initial begin
    int rx, ry, rz, lvl, sx, sy, sz, r, d, phase_end;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      case (PLAN[i].kind)
        ROW_CFG:   set_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
        ROW_WRITE: push_item(CMD_WRITE, PLAN[i].x, PLAN[i].y, PLAN[i].z, PLAN[i].val);
        default:   sample_at(PLAN[i].x, PLAN[i].y, PLAN[i].z, PLAN[i].val,
                             PLAN[i].typed, PLAN[i].want);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          rx = 127; ry = 127; rz = 127; lvl = 0; sx = 0; sy = 0; sz = 0;
        end
        1: begin
          rx = 64; ry = 64; rz = 64; lvl = 200; sx = 15; sy = 15; sz = 15;
        end
        2, 3: begin
          rx = (p == 2) ? 1 : 0;
          ry = rx;
          rz = rx;
          lvl = $urandom_range(0, 255);
          sx = $urandom_range(0, 15); sy = $urandom_range(0, 15); sz = $urandom_range(0, 15);
        end
        default: begin
          rx = pick_res(); ry = pick_res(); rz = pick_res();
          lvl = $urandom_range(0, 255);
          sx = $urandom_range(0, 15); sy = $urandom_range(0, 15); sz = $urandom_range(0, 15);
        end
      endcase
      set_reg(CFG_RES_X, 8'(rx));
      set_reg(CFG_RES_Y, 8'(ry));
      set_reg(CFG_RES_Z, 8'(rz));
      set_reg(CFG_ISO_LEVEL, 8'(lvl));
      set_reg(CFG_STEP_X, 8'(sx));
      set_reg(CFG_STEP_Y, 8'(sy));
      set_reg(CFG_STEP_Z, 8'(sz));

      // keep most coordinates in a small box so neighbors get reused
      for (int a = 0; a < 3; a++) begin
        d = eff_dim((a == 0) ? dim_x : (a == 1) ? dim_y : dim_z);
        win_span[a] = (d < 6) ? d : 6;
        win_lo[a] = $urandom_range(0, d - win_span[a]);
      end

      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 55)
          sample_at(pick_coord(0), pick_coord(1), pick_coord(2), $urandom_range(0, 255));
        else if (r < 90)
          push_item(CMD_WRITE, pick_coord(0), pick_coord(1), pick_coord(2), pick_voxel());
        else
          push_item(CMD_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 63), pick_voxel());
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("voxel_iso_gradient_sampler verification clean");
    end else begin
      $display("voxel_iso_gradient_sampler verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("voxel_iso_gradient_sampler verification failed");
    $finish;
  end

endmodule

`default_nettype wire
